>>> sv/ifmt_pkg.sv
`default_nettype none
package ifmt_pkg;

  localparam int VALUE_BITS   = 64;
  localparam int MAX_WIDTH    = 64;
  localparam int DIGIT_BUFFER = 64;
  localparam int PREC_MAX     = 60;
  localparam int OUT_MAX      = 64;

  localparam int NDIG   = (VALUE_BITS + 2) / 3;
  localparam int DIG_W  = 4 * NDIG;
  localparam int LEN_W  = $clog2(DIGIT_BUFFER + 1);
  localparam int CONV_W = $clog2(VALUE_BITS);
  localparam int POS_W  = 8;

  typedef enum logic [1:0] {
    BASE_OCT    = 2'd0,
    BASE_DEC    = 2'd1,
    BASE_HEX_LO = 2'd2,
    BASE_HEX_UP = 2'd3
  } base_t;

  localparam int FL_LEFT  = 0;
  localparam int FL_PLUS  = 1;
  localparam int FL_SPACE = 2;
  localparam int FL_ALT   = 3;
  localparam int FL_ZERO  = 4;
  localparam int FL_GROUP = 5;

  localparam logic [4:0] CODE_COMMA = 5'd16;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;

endpackage
`default_nettype wire

>>> sv/integer_to_text_formatter.sv
`default_nettype none
// Renders one integer as printf does for %o, %d, %x and %X, one ASCII character per
// output item, the last character marked by last_char; an item that renders to nothing
// gives no output. The block takes one item at a time and holds in_stall high until the
// last character is in the output register. A decimal item first passes through a
// bit-serial binary-to-BCD shift register; octal and hex skip that step. Then each digit
// or comma is pushed onto the digit stack (S_GEN), then each zero of precision (S_EXT),
// and a closing step also pushes the octal leading zero. Sizing runs in S_PAD and
// S_BOUND, and the characters then go out in order while the output is not stalled.
module integer_to_text_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] magnitude,
  input  logic        signed_conv,
  input  logic        is_negative,
  input  logic [1:0]  base_sel,
  input  logic [5:0]  flag_bits,
  input  logic [6:0]  field_width,
  input  logic signed [6:0] min_digits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_out,
  output logic        last_char
);
  import ifmt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_GEN, S_EXT, S_PAD, S_BOUND, S_EMIT
  } state_t;

  state_t               state;
  logic [DIG_W-1:0]     dig;
  logic [VALUE_BITS-1:0] bin;
  logic [CONV_W-1:0]    conv_cnt;
  base_t                base;
  logic                 left_f, zero_f, alt_f, group_f, sign_en, x_en;
  logic [7:0]           sign_ch;
  logic [LEN_W-1:0]     prec;
  logic [6:0]           width_r;
  logic [4:0]           stk [DIGIT_BUFFER];
  logic [LEN_W-1:0]     len;
  logic [1:0]           gcnt;
  logic                 started, comma_done;
  logic [POS_W-1:0]     pad, b_a, b_b, b_c, b_d, b_e, pos;

  logic [VALUE_BITS-1:0] val;
  logic [DIG_W-1:0]     dig_map, dig_adj, oct_pad, hex_pad;
  logic                 plus_a, space_a, zero_a, neg_a;
  logic [7:0]           sign_a;
  logic [LEN_W-1:0]     prec_a;
  logic [6:0]           width_a;
  logic [POS_W-1:0]     sum, e_full;
  logic [7:0]           dig_ch, ch;
  logic                 need_comma, emit_go, emit_fire, is_digit;
  logic [1:0]           grp_last;

  assign val = magnitude[VALUE_BITS-1:0];
  assign in_stall = (state != S_IDLE);

  always_comb begin
    oct_pad = DIG_W'(val);
    hex_pad = DIG_W'(val);
    for (int i = 0; i < NDIG; i++) begin
      if (base_t'(base_sel) == BASE_OCT) begin
        dig_map[4*i +: 4] = {1'b0, oct_pad[3*i +: 3]};
      end else begin
        dig_map[4*i +: 4] = hex_pad[4*i +: 4];
      end
      dig_adj[4*i +: 4] = (dig[4*i +: 4] >= 4'd5) ? dig[4*i +: 4] + 4'd3 : dig[4*i +: 4];
    end
  end

  always_comb begin
    neg_a   = is_negative;
    plus_a  = flag_bits[FL_PLUS];
    space_a = flag_bits[FL_SPACE] & ~plus_a;
    zero_a  = flag_bits[FL_ZERO] & ~flag_bits[FL_LEFT] & min_digits[6];
    sign_a  = 8'd0;
    if (signed_conv) begin
      if (plus_a) begin
        sign_a = neg_a ? CH_MINUS : CH_PLUS;
      end else if (space_a) begin
        sign_a = neg_a ? CH_MINUS : CH_SPACE;
      end else if (neg_a) begin
        sign_a = CH_MINUS;
      end
    end
    if (min_digits[6]) begin
      prec_a = LEN_W'(1);
    end else if (min_digits > 7'(PREC_MAX)) begin
      prec_a = LEN_W'(PREC_MAX);
    end else begin
      prec_a = LEN_W'(min_digits[5:0]);
    end
    width_a = (field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : field_width;
  end

  always_comb begin
    grp_last   = base[1] ? 2'd3 : 2'd2;
    need_comma = group_f && started && (gcnt == 2'd0) && !comma_done;
    sum        = POS_W'(len) + (x_en ? POS_W'(2) : POS_W'(0)) + (sign_en ? POS_W'(1) : POS_W'(0));
    e_full     = b_e + (left_f ? pad : POS_W'(0));
    if (stk[0] == CODE_COMMA) begin
      dig_ch = CH_COMMA;
    end else if (stk[0][3:0] < 4'd10) begin
      dig_ch = CH_ZERO + {4'd0, stk[0][3:0]};
    end else if (base == BASE_HEX_UP) begin
      dig_ch = CH_UPPER_A + {4'd0, stk[0][3:0]} - 8'd10;
    end else begin
      dig_ch = CH_LOWER_A + {4'd0, stk[0][3:0]} - 8'd10;
    end
    is_digit = 1'b0;
    if (pos < b_a) begin
      ch = CH_SPACE;
    end else if (pos < b_b) begin
      ch = sign_ch;
    end else if (pos < b_c) begin
      ch = (pos == b_b) ? CH_ZERO : ((base == BASE_HEX_UP) ? CH_UPPER_X : CH_LOWER_X);
    end else if (pos < b_d) begin
      ch = CH_ZERO;
    end else if (pos < b_e) begin
      ch = dig_ch;
      is_digit = 1'b1;
    end else begin
      ch = CH_SPACE;
    end
    emit_go   = !out_valid || !out_stall;
    emit_fire = (state == S_EMIT) && (e_full != '0) && emit_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            base       <= base_t'(base_sel);
            left_f     <= flag_bits[FL_LEFT];
            zero_f     <= zero_a;
            alt_f      <= flag_bits[FL_ALT];
            group_f    <= flag_bits[FL_GROUP];
            sign_ch    <= sign_a;
            sign_en    <= (sign_a != 8'd0);
            x_en       <= base_sel[1] & flag_bits[FL_ALT] & (val != '0);
            prec       <= prec_a;
            width_r    <= width_a;
            len        <= '0;
            gcnt       <= 2'd0;
            started    <= 1'b0;
            comma_done <= 1'b0;
            conv_cnt   <= '0;
            bin        <= val;
            if (base_t'(base_sel) == BASE_DEC) begin
              dig   <= '0;
              state <= S_CONV;
            end else begin
              dig   <= dig_map;
              state <= S_GEN;
            end
          end
        end
        S_CONV: begin
          dig      <= {dig_adj[DIG_W-2:0], bin[VALUE_BITS-1]};
          bin      <= bin << 1;
          conv_cnt <= conv_cnt + 1'b1;
          if (conv_cnt == CONV_W'(VALUE_BITS - 1)) begin
            state <= S_GEN;
          end
        end
        S_GEN: begin
          if (dig == '0 || len == LEN_W'(DIGIT_BUFFER)) begin
            state <= S_EXT;
          end else begin
            for (int i = 1; i < DIGIT_BUFFER; i++) begin
              stk[i] <= stk[i-1];
            end
            len <= len + 1'b1;
            if (need_comma) begin
              stk[0]     <= CODE_COMMA;
              comma_done <= 1'b1;
            end else begin
              stk[0]     <= {1'b0, dig[3:0]};
              dig        <= dig >> 4;
              gcnt       <= (gcnt == grp_last) ? 2'd0 : gcnt + 2'd1;
              started    <= 1'b1;
              comma_done <= 1'b0;
            end
          end
        end
        S_EXT: begin
          if (len < prec && len < LEN_W'(DIGIT_BUFFER - 1)) begin
            for (int i = 1; i < DIGIT_BUFFER; i++) begin
              stk[i] <= stk[i-1];
            end
            stk[0] <= 5'd0;
            len    <= len + 1'b1;
          end else begin
            if (alt_f && base == BASE_OCT && (len == '0 || stk[0] != 5'd0) &&
                len < LEN_W'(DIGIT_BUFFER)) begin
              for (int i = 1; i < DIGIT_BUFFER; i++) begin
                stk[i] <= stk[i-1];
              end
              stk[0] <= 5'd0;
              len    <= len + 1'b1;
            end
            state <= S_PAD;
          end
        end
        S_PAD: begin
          pad   <= (POS_W'(width_r) > sum) ? POS_W'(width_r) - sum : POS_W'(0);
          state <= S_BOUND;
        end
        S_BOUND: begin
          b_a   <= (!left_f && !zero_f) ? pad : POS_W'(0);
          b_b   <= ((!left_f && !zero_f) ? pad : POS_W'(0)) + (sign_en ? POS_W'(1) : POS_W'(0));
          b_c   <= ((!left_f && !zero_f) ? pad : POS_W'(0)) + (sign_en ? POS_W'(1) : POS_W'(0))
                   + (x_en ? POS_W'(2) : POS_W'(0));
          b_d   <= ((!left_f && !left_f && !zero_f) ? pad : POS_W'(0))
                   + (sign_en ? POS_W'(1) : POS_W'(0)) + (x_en ? POS_W'(2) : POS_W'(0))
                   + (zero_f ? pad : POS_W'(0));
          b_e   <= pad - (left_f ? pad : POS_W'(0)) + sum;
          pos   <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (e_full == '0) begin
            state <= S_IDLE;
          end else if (emit_go) begin
            char_out <= ch;
            pos      <= pos + 1'b1;
            if (is_digit) begin
              for (int i = 0; i < DIGIT_BUFFER - 1; i++) begin
                stk[i] <= stk[i+1];
              end
              stk[DIGIT_BUFFER-1] <= 5'd0;
            end
            if (pos + 1'b1 == ((e_full > POS_W'(OUT_MAX)) ? POS_W'(OUT_MAX) : e_full)) begin
              last_char <= 1'b1;
              state     <= S_IDLE;
            end else begin
              last_char <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/ifmt_checker.sv
`default_nettype none
module ifmt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] char_out,
  input logic       last_char
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(last_char))
    else $error("stalled output item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took an item without going busy");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_char |=> out_valid)
    else $error("gap inside a rendered item");

  a_busy_while_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_char |-> in_stall)
    else $error("input open before the last character");

endmodule

bind integer_to_text_formatter ifmt_checker u_ifmt_checker (.*);
`default_nettype wire

>>> test/integer_to_text_formatter_checker.sv
`timescale 1ns / 1ps
module integer_to_text_formatter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] magnitude,
  input  logic        signed_conv,
  input  logic        is_negative,
  input  logic [1:0]  base_sel,
  input  logic [5:0]  flag_bits,
  input  logic [6:0]  field_width,
  input  logic [6:0]  min_digits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  char_out,
  input  logic        last_char,
  output int          fail_count,
  output int          pending_chars
);
  import ifmt_pkg::*;

  logic [8:0] expected_chars[$];

  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    if (d < 4'd10) return CH_ZERO + 8'(d);
    return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(d) - 8'd10;
  endfunction

  task automatic render_integer(logic [63:0] val, logic sgn, logic neg, base_t bsel,
                                logic [5:0] fl_in, logic [6:0] wraw, logic [6:0] praw);
    logic [5:0] fl;
    int prec, width, base, grp, len, dcnt, pad, n, i;
    logic [7:0] sign_ch, x_ch;
    logic [7:0] buffer[64];
    logic [7:0] text[$];
    fl = fl_in;
    if (fl[FL_LEFT]) fl[FL_ZERO] = 1'b0;
    if (fl[FL_PLUS]) fl[FL_SPACE] = 1'b0;
    if (!praw[6]) fl[FL_ZERO] = 1'b0;
    prec = praw[6] ? 1 : (int'(praw) > PREC_MAX ? PREC_MAX : int'(praw));
    width = int'(wraw) > MAX_WIDTH ? MAX_WIDTH : int'(wraw);
    base = (bsel == BASE_OCT) ? 8 : (bsel == BASE_DEC) ? 10 : 16;
    grp = (base == 16) ? 4 : 3;
    x_ch = (bsel == BASE_HEX_LO) ? CH_LOWER_X : (bsel == BASE_HEX_UP) ? CH_UPPER_X : 8'h00;
    sign_ch = 8'h00;
    if (sgn) begin
      if (fl[FL_PLUS]) sign_ch = neg ? CH_MINUS : CH_PLUS;
      else if (fl[FL_SPACE]) sign_ch = neg ? CH_MINUS : CH_SPACE;
      else if (neg) sign_ch = CH_MINUS;
    end
    if (!(fl[FL_ALT] && val != 0)) x_ch = 8'h00;
    len = 0;
    dcnt = 0;
    while (val > 0 && len < DIGIT_BUFFER) begin
      if (fl[FL_GROUP] && dcnt > 0 && dcnt % grp == 0) begin
        buffer[len] = CH_COMMA;
        len++;
        if (len >= DIGIT_BUFFER) break;
      end
      buffer[len] = digit_char(4'(val % base), bsel == BASE_HEX_UP);
      len++;
      val = val / base;
      dcnt++;
    end
    while (len < prec && len < DIGIT_BUFFER - 1) begin
      buffer[len] = CH_ZERO;
      len++;
    end
    if (fl[FL_ALT] && base == 8 && (len == 0 || buffer[len-1] != CH_ZERO)
        && len < DIGIT_BUFFER) begin
      buffer[len] = CH_ZERO;
      len++;
    end
    pad = width - len - (x_ch != 0 ? 2 : 0) - (sign_ch != 0 ? 1 : 0);
    if (pad < 0) pad = 0;
    if (!fl[FL_LEFT] && !fl[FL_ZERO]) for (i = 0; i < pad; i++) text.push_back(CH_SPACE);
    if (sign_ch != 0) text.push_back(sign_ch);
    if (x_ch != 0) begin
      text.push_back(CH_ZERO);
      text.push_back(x_ch);
    end
    if (fl[FL_ZERO]) for (i = 0; i < pad; i++) text.push_back(CH_ZERO);
    while (len > 0) begin
      len--;
      text.push_back(buffer[len]);
    end
    if (fl[FL_LEFT]) for (i = 0; i < pad; i++) text.push_back(CH_SPACE);
    n = text.size() > OUT_MAX ? OUT_MAX : text.size();
    for (i = 0; i < n; i++) expected_chars.push_back({i == n - 1, text[i]});
  endtask

  always @(posedge clk) begin
    logic [8:0] exp_char;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      pending_chars <= 0;
    end else begin
      if (in_valid && !in_stall)
        render_integer(magnitude, signed_conv, is_negative, base_t'(base_sel), flag_bits,
                       field_width, min_digits);
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $error("char_out: unexpected character %h", char_out);
          errs = errs + 1;
        end else begin
          exp_char = expected_chars.pop_front();
          if (char_out !== exp_char[7:0]) begin
            $error("char_out: expected %h, actual %h", exp_char[7:0], char_out);
            errs = errs + 1;
          end
          if (last_char !== exp_char[8]) begin
            $error("last_char: expected %b, actual %b", exp_char[8], last_char);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_chars <= expected_chars.size();
    end
  end

endmodule

>>> test/integer_to_text_formatter_tb.sv
`timescale 1ns / 1ps
module integer_to_text_formatter_tb;
  import ifmt_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] magnitude = '0;
  logic        signed_conv = 1'b0;
  logic        is_negative = 1'b0;
  logic [1:0]  base_sel = BASE_OCT;
  logic [5:0]  flag_bits = '0;
  logic [6:0]  field_width = '0;
  logic [6:0]  min_digits = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [7:0]  char_out;
  logic        last_char;
  int          fail_count;
  int          pending_chars;
  bit          steady_phase = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  integer_to_text_formatter u_top (.*);

  integer_to_text_formatter_checker u_checker (.*);

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b1;
    else out_stall <= steady_phase ? 1'b0 : ($urandom_range(99) < 29);
  end

  task automatic send_item(logic [63:0] m, logic s, logic n, logic [1:0] b,
                           logic [5:0] f, logic [6:0] w, logic [6:0] p);
    while (!steady_phase && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    magnitude <= m;
    signed_conv <= s;
    is_negative <= n;
    base_sel <= b;
    flag_bits <= f;
    field_width <= w;
    min_digits <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [63:0] random_magnitude();
    case ($urandom_range(4))
      0: return 64'($urandom_range(20));
      1: return 64'($urandom);
      2: return {$urandom, $urandom};
      3: return {$urandom, $urandom} >> $urandom_range(63);
      default: return {64{1'b1}} - $urandom_range(3);
    endcase
  endfunction

  function automatic logic [6:0] random_precision();
    case ($urandom_range(5))
      0: return 7'($urandom_range(127));
      1: return 7'h7f;
      2: return 7'($urandom_range(64, 127));
      default: return 7'($urandom_range(12));
    endcase
  endfunction

  initial begin
    int i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_item(64'd0, 1'b0, 1'b0, BASE_DEC, 6'd0, 7'd0, 7'd0);
    send_item(64'd0, 1'b1, 1'b1, BASE_DEC, 6'd0, 7'd0, 7'h7f);
    send_item({64{1'b1}}, 1'b0, 1'b0, BASE_OCT, 6'h3f, 7'd127, 7'd60);
    send_item({64{1'b1}}, 1'b0, 1'b0, BASE_DEC, 6'h20, 7'd64, 7'h7f);
    send_item({64{1'b1}}, 1'b1, 1'b1, BASE_HEX_LO, 6'h2a, 7'd0, 7'd63);
    send_item(64'hdeadbeef, 1'b1, 1'b0, BASE_HEX_UP, 6'h08, 7'd20, 7'h7f);
    send_item(64'd12345, 1'b1, 1'b0, BASE_DEC, 6'h02, 7'd10, 7'h7f);
    send_item(64'd12345, 1'b1, 1'b0, BASE_DEC, 6'h04, 7'd10, 7'h7f);
    send_item(64'd12345, 1'b1, 1'b1, BASE_DEC, 6'h06, 7'd10, 7'h7f);
    send_item(64'd42, 1'b1, 1'b1, BASE_DEC, 6'h10, 7'd10, 7'h7f);
    send_item(64'd42, 1'b1, 1'b1, BASE_DEC, 6'h11, 7'd10, 7'h7f);
    send_item(64'd42, 1'b1, 1'b0, BASE_DEC, 6'h10, 7'd10, 7'd5);
    send_item(64'd8, 1'b0, 1'b0, BASE_OCT, 6'h08, 7'd0, 7'h7f);
    send_item(64'd0, 1'b0, 1'b0, BASE_OCT, 6'h08, 7'd0, 7'd0);
    send_item(64'd0, 1'b0, 1'b0, BASE_HEX_LO, 6'h08, 7'd4, 7'h7f);
    send_item(64'h123456789, 1'b0, 1'b0, BASE_HEX_LO, 6'h38, 7'd30, 7'h7f);
    send_item(64'd1234567, 1'b0, 1'b0, BASE_DEC, 6'h20, 7'd0, 7'd20);
    send_item(64'd7, 1'b0, 1'b1, BASE_OCT, 6'h01, 7'd64, 7'd60);
    send_item(64'd0, 1'b1, 1'b0, BASE_DEC, 6'h02, 7'd0, 7'd0);
    for (i = 0; i < 300; i++) begin
      if (i == 150) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars != 0) @(posedge clk);
        repeat (250) @(posedge clk);
        steady_phase = 1'b1;
      end
      if (i == 200) steady_phase = 1'b0;
      send_item(random_magnitude(), 1'($urandom), 1'($urandom), 2'($urandom),
                6'($urandom), ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                : 7'($urandom_range(24)), random_precision());
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
